### design/pccd_pkg.sv
package pccd_pkg;

  // Table depth used when the top level is not given another value.
  localparam int DEFAULT_MAX_ENTITIES = 32;

  localparam int ID_W  = 16;
  localparam int POS_W = 16;
  localparam int RAD_W = 15;

  // One stored circle: 16 + 16 + 16 + 15 = 63 bits.
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [RAD_W-1:0]        r;
  } circle_t;

  // Result of the overlap pipeline for the entry in its last stage.
  typedef struct packed {
    logic            busy;
    logic            valid;
    logic            overlap;
    logic [ID_W-1:0] earlier_id;
  } ovl_status_t;

endpackage

### design/pccd_table.sv
module pccd_table #(
  parameter int Depth = pccd_pkg::DEFAULT_MAX_ENTITIES,
  localparam int IdxW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  pccd_pkg::circle_t     wr_data_i,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  output pccd_pkg::circle_t     rd_data_o
);

  pccd_pkg::circle_t mem_q [Depth];
  pccd_pkg::circle_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read register holds its value while the scan is held up.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/pccd_overlap.sv
module pccd_overlap (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  entry_valid_i,
  input  pccd_pkg::circle_t     entry_i,
  input  pccd_pkg::circle_t     cur_i,
  output pccd_pkg::ovl_status_t status_o
);

  // Stage two holds the differences, stage three the squares.
  logic                      v2_q, v3_q;
  logic signed [16:0]        dx_q, dy_q;
  logic [15:0]               rs_q;
  logic [pccd_pkg::ID_W-1:0] id2_q, id3_q;
  logic [31:0]               sqx_q, sqy_q, rs2_q;
  logic signed [33:0]        prod_x, prod_y;
  logic [31:0]               prod_r;
  logic [32:0]               dist2;

  assign prod_x = 34'(dx_q) * 34'(dx_q);
  assign prod_y = 34'(dy_q) * 34'(dy_q);
  assign prod_r = 32'(rs_q) * 32'(rs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= entry_valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q  <= {entry_i.x[15], entry_i.x} - {cur_i.x[15], cur_i.x};
      dy_q  <= {entry_i.y[15], entry_i.y} - {cur_i.y[15], cur_i.y};
      rs_q  <= 16'(entry_i.r) + 16'(cur_i.r);
      id2_q <= entry_i.id;
      // Squares of values below 2^16 in magnitude fit in 32 bits.
      sqx_q <= prod_x[31:0];
      sqy_q <= prod_y[31:0];
      rs2_q <= prod_r;
      id3_q <= id2_q;
    end
  end

  assign dist2 = 33'(sqx_q) + 33'(sqy_q);

  assign status_o.busy       = v2_q | v3_q;
  assign status_o.valid      = v3_q;
  assign status_o.overlap    = dist2 < {1'b0, rs2_q};
  assign status_o.earlier_id = id3_q;

endmodule

### design/pairwise_circle_collision_detector.sv
// Pairwise circle collision detector.
// Input channel: one transaction per entity (start_frame, entity_id, pos_x,
// pos_y, radius). A transaction with start_frame set empties the entity
// table before the entity is tested. Output channel: one transaction per
// overlapping pair (earlier_entity, later_entity, last_in_run), in table
// order, with last_in_run set on the final pair caused by an entity.
// Both channels move a transaction at a clock edge where valid is high and
// stall is low. One entity is handled at a time: in_stall_o is high from the
// cycle after acceptance until its run ends and the entity is stored; an
// entity that finds the table full is not stored. It is tested against every
// entry of the frame in turn through the single read port of the table,
// read once per stored entry. The first pair passes the table read register,
// the overlap stages, the pending-pair register and the output register.
// Reset empties the frame and leaves both channels idle; the table contents
// need no clearing, since only written entries are ever read.
// A stall on the output holds the whole scan pipeline, so no pair is lost.
module pairwise_circle_collision_detector #(
  parameter int MAX_ENTITIES = pccd_pkg::DEFAULT_MAX_ENTITIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_frame_i,
  input  logic [15:0] entity_id_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [14:0] radius_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] earlier_entity_o,
  output logic [15:0] later_entity_o,
  output logic        last_in_run_o
);

  localparam int CntW = $clog2(MAX_ENTITIES + 1);
  localparam int IdxW = $clog2(MAX_ENTITIES);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_ENTITIES);
  localparam logic [CntW-1:0] MaxPairs = CntW'(MAX_ENTITIES - 1);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e                state_q;
  logic [CntW-1:0]       stored_q;   // entries in the current frame
  logic [CntW-1:0]       scan_len_q; // entries the current entity is tested against
  logic [CntW-1:0]       issue_q;    // next table entry to read
  logic [CntW-1:0]       pairs_q;    // pairs found so far, pending one included
  logic                  v1_q;       // read data register holds a live entry
  logic                  pend_v_q;
  logic [15:0]           pend_id_q;
  pccd_pkg::circle_t     cur_q;
  logic                  out_valid_q;
  logic [15:0]           earlier_q, later_q;
  logic                  last_q;

  pccd_pkg::circle_t     rd_data;
  pccd_pkg::ovl_status_t ovl;

  logic in_accept, adv, issuing, scan_done, hit, out_load, flush_go, wr_en;

  // The scan only moves when the output register can take a pair.
  assign adv       = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && (state_q == StIdle);
  assign issuing   = (state_q == StScan) && (issue_q != scan_len_q);
  assign scan_done = (state_q == StScan) && !issuing && !v1_q && !ovl.busy;

  // Pairs beyond the cap are dropped; equal ids never pair.
  assign hit = ovl.valid && ovl.overlap && (ovl.earlier_id != cur_q.id) &&
               (pairs_q != MaxPairs);

  assign flush_go = (state_q == StFlush) && adv;
  // A new hit pushes the pending pair out; the flush pushes the final one.
  assign out_load = adv && pend_v_q && (hit || (state_q == StFlush));
  assign wr_en    = flush_go && (stored_q != MaxCount);

  pccd_table #(
    .Depth(MAX_ENTITIES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (stored_q[IdxW-1:0]),
    .wr_data_i (cur_q),
    .rd_en_i   (adv && issuing),
    .rd_addr_i (issue_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  pccd_overlap u_overlap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .entry_valid_i (v1_q),
    .entry_i       (rd_data),
    .cur_i         (cur_q),
    .status_o      (ovl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      stored_q    <= '0;
      scan_len_q  <= '0;
      issue_q     <= '0;
      pairs_q     <= '0;
      v1_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_accept) begin
            issue_q <= '0;
            pairs_q <= '0;
            if (start_frame_i) begin
              stored_q   <= '0;
              scan_len_q <= '0;
              state_q    <= StFlush;
            end else begin
              scan_len_q <= stored_q;
              state_q    <= (stored_q == '0) ? StFlush : StScan;
            end
          end
        end
        StScan: begin
          if (adv) begin
            v1_q <= issuing;
            if (issuing) begin
              issue_q <= issue_q + CntW'(1);
            end
            if (hit) begin
              pend_v_q <= 1'b1;
              pairs_q  <= pairs_q + CntW'(1);
            end
          end
          if (scan_done) begin
            state_q <= StFlush;
          end
        end
        StFlush: begin
          if (flush_go) begin
            pend_v_q <= 1'b0;
            state_q  <= StIdle;
            if (wr_en) begin
              stored_q <= stored_q + CntW'(1);
            end
          end
        end
        default: state_q <= StIdle;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_q.id <= entity_id_i;
      cur_q.x  <= pos_x_i;
      cur_q.y  <= pos_y_i;
      cur_q.r  <= radius_i;
    end
    if (adv && hit && (state_q == StScan)) begin
      pend_id_q <= ovl.earlier_id;
    end
    if (out_load) begin
      earlier_q <= pend_id_q;
      later_q   <= cur_q.id;
      last_q    <= (state_q == StFlush);
    end
  end

  assign in_stall_o       = (state_q != StIdle);
  assign out_valid_o      = out_valid_q;
  assign earlier_entity_o = earlier_q;
  assign later_entity_o   = later_q;
  assign last_in_run_o    = last_q;

endmodule

### design/pccd_checker.sv
module pccd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] earlier_entity_o,
  input logic [15:0] later_entity_o,
  input logic        last_in_run_o
);

  // A stalled pair stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // A stalled pair keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(earlier_entity_o) &&
    $stable(later_entity_o) && $stable(last_in_run_o))
    else $error("output payload changed under stall");

  // An entity never pairs with a stored entity of the same id.
  a_no_self_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> earlier_entity_o != later_entity_o)
    else $error("pair with equal ids");

  // While a pair that is not the last one is offered, the run is still open.
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_in_run_o |-> in_stall_o)
    else $error("new entity accepted before the run was closed");

endmodule

bind pairwise_circle_collision_detector pccd_checker u_pccd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .earlier_entity_o (earlier_entity_o),
  .later_entity_o   (later_entity_o),
  .last_in_run_o    (last_in_run_o)
);
